>>> rtl/wildcard_glob_matcher_core_assert.svh
// Assertion macros for the wildcard glob matcher.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef WILDCARD_GLOB_MATCHER_CORE_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define WGM_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define WGM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define WGM_ASSERT_CLK(lbl, prop, msg)

`define WGM_ASSERT_IMPLY(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/wgm_pkg.sv
// Shared types and constants of the wildcard glob matcher.
// Used by wgm_cell and wildcard_glob_matcher_core; depends on nothing.
package wgm_pkg;

  localparam int MAX_PATTERN_DEF = 128;

  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_END    = 2'd3;

  // Pattern wildcards: '?' and '*'.
  localparam logic [BYTE_W-1:0] CH_ANY  = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } state_t;

  // Values broadcast from the controller to every cell.
  typedef struct packed {
    logic              step_mode;  // 1: text byte update, 0: empty-text row rebuild
    logic [BYTE_W-1:0] text_byte;
    logic              wr_en;
    logic [BYTE_W-1:0] wr_byte;
  } bcast_t;

  // Data handed from one cell to the next.
  typedef struct packed {
    logic token;  // sweep position marker
    logic n;      // new row bit of the previous position
    logic d;      // old row bit of the previous position
  } link_t;

endpackage

>>> rtl/wgm_cell.sv
// One pattern position of the matcher: holds a pattern byte and its row bit.
// Depends on wgm_pkg for the broadcast and link structs.
module wgm_cell import wgm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int IDX         = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bcast_t                           bc,
  input  logic [$clog2(MAX_PATTERN+1)-1:0] len,
  input  link_t                            link_in,
  output link_t                            link_out
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [BYTE_W-1:0] pat_r;
  logic              d_r;
  logic              d_nxt;
  logic              tok_r;
  logic              n_r;
  logic              dout_r;
  logic              in_use;
  logic              is_star;
  logic              hit;

  assign in_use  = len > LEN_W'(IDX);
  assign is_star = pat_r == CH_STAR;
  assign hit     = (pat_r == bc.text_byte) || (pat_r == CH_ANY);

  always_comb begin
    if (!bc.step_mode) begin
      d_nxt = link_in.n & is_star;
    end else if (is_star) begin
      d_nxt = link_in.n | d_r;
    end else begin
      d_nxt = link_in.d & hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= link_in.token;
    end
  end

  // Positions past the pattern end just forward the running bit, so the last
  // cell always delivers the row bit at the pattern length.
  always_ff @(posedge clk) begin
    if (link_in.token) begin
      if (in_use) begin
        d_r <= d_nxt;
        n_r <= d_nxt;
      end else begin
        n_r <= link_in.n;
      end
      dout_r <= d_r;
    end
    if (bc.wr_en && (len == LEN_W'(IDX))) begin
      pat_r <= bc.wr_byte;
    end
  end

  assign link_out = '{token: tok_r, n: n_r, d: dout_r};

endmodule

>>> rtl/wildcard_glob_matcher_core.sv
// Wildcard glob matcher: each accepted word starts a sweep down a row of
// MAX_PATTERN cells, one cell per cycle, and no new word is accepted until
// that sweep is done. An end-of-text result is in the output register in
// the cycle after its word is accepted. Synchronous active-low reset leaves an
// empty pattern and the empty-text row, ready for a word in the next cycle.
`include "wildcard_glob_matcher_core_assert.svh"

module wildcard_glob_matcher_core import wgm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [BYTE_W-1:0] in_byte_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_matched,
  output logic              out_pattern_overflowed
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  len_r;
  logic              ovf_r;
  logic              row0_r;
  logic              result_r;
  logic              start_r;
  logic              seed_n_r;
  logic              seed_d_r;
  logic              step_mode_r;
  logic [BYTE_W-1:0] text_byte_r;
  logic              out_valid_r;
  logic              out_matched_r;
  logic              out_ovf_r;
  logic              in_fire;
  logic              out_fire;
  logic              not_full;
  logic              sweep_done;
  bcast_t            bc;
  link_t             chain [MAX_PATTERN+1];
  logic [MAX_PATTERN:0] tok_vec;

  assign in_fire    = in_valid && in_ready;
  assign out_fire   = out_valid_r && out_ready;
  assign not_full   = len_r < LEN_W'(MAX_PATTERN);
  assign sweep_done = chain[MAX_PATTERN].token;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_SWEEP;
      ST_SWEEP: if (sweep_done) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // An end-of-text word needs the output register free; other words do not.
  always_comb begin
    case (state_r)
      ST_IDLE:  in_ready = !out_valid_r || out_ready || (in_cmd != CMD_END);
      default:  in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      row0_r      <= 1'b1;
      result_r    <= 1'b1;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_fire;
      if (sweep_done) begin
        result_r <= chain[MAX_PATTERN].n;
      end
      if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire) begin
        case (in_cmd)
          CMD_CLEAR: begin
            len_r  <= '0;
            ovf_r  <= 1'b0;
            row0_r <= 1'b1;
          end
          CMD_APPEND: begin
            if (not_full) begin
              len_r <= len_r + LEN_W'(1);
            end else begin
              ovf_r <= 1'b1;
            end
            row0_r <= 1'b1;
          end
          CMD_TEXT: begin
            row0_r <= 1'b0;
          end
          default: begin
            row0_r      <= 1'b1;
            out_valid_r <= 1'b1;
          end
        endcase
      end
    end
  end

  // Sweep seed and output payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      step_mode_r <= in_cmd == CMD_TEXT;
      text_byte_r <= in_byte_value;
      seed_n_r    <= in_cmd != CMD_TEXT;
      seed_d_r    <= row0_r;
      if (in_cmd == CMD_END) begin
        out_matched_r <= result_r;
        out_ovf_r     <= ovf_r;
      end
    end
  end

  assign bc = '{step_mode: step_mode_r, text_byte: text_byte_r,
                wr_en: in_fire && (in_cmd == CMD_APPEND) && not_full,
                wr_byte: in_byte_value};

  assign chain[0] = '{token: start_r, n: seed_n_r, d: seed_d_r};

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    wgm_cell #(
      .MAX_PATTERN (MAX_PATTERN),
      .IDX         (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .bc       (bc),
      .len      (len_r),
      .link_in  (chain[i]),
      .link_out (chain[i+1])
    );
  end

  always_comb begin
    for (int k = 0; k <= MAX_PATTERN; k++) begin
      tok_vec[k] = chain[k].token;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_matched            = out_matched_r;
  assign out_pattern_overflowed = out_ovf_r;

  `WGM_ASSERT_CLK(a_one_token, $onehot0(tok_vec), "more than one sweep in flight")
  `WGM_ASSERT_IMPLY(a_idle_quiet, state_r == ST_IDLE, tok_vec == '0, "sweep active while idle")
  `WGM_ASSERT_CLK(a_len_range, len_r <= LEN_W'(MAX_PATTERN), "pattern length past capacity")
  `WGM_ASSERT_IMPLY(a_ovf_full, ovf_r, len_r == LEN_W'(MAX_PATTERN), "overflow with room left")

endmodule
